[hw/rtl/palette_candy_strobe_core_macros.svh]
// Assertion helpers shared by the checker
`ifndef PALETTE_CANDY_STROBE_CORE_MACROS_SVH
`define PALETTE_CANDY_STROBE_CORE_MACROS_SVH

// Same-cycle implication, reset disabled
`define PCS_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, reset disabled
`define PCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/pcs_pkg.sv]
`timescale 1ns / 1ps
package pcs_pkg;

  localparam int unsigned PaletteSlotsDefault = 8;

  localparam int unsigned CodeW    = 64;
  localparam int unsigned CountW   = 4;
  localparam int unsigned TicksW   = 15;
  localparam int unsigned BatchW   = 8;
  localparam int unsigned RepeatW  = 8;
  localparam int unsigned TickCntW = 16;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // remainder unit: 9-bit dividend, three quotient bits per step
  localparam int unsigned DivW        = 9;
  localparam int unsigned RemW        = 4;
  localparam int unsigned BitsPerStep = 3;
  localparam int unsigned ModSteps    = DivW / BitsPerStep;
  localparam int unsigned StepW       = $clog2(ModSteps);

  typedef enum logic [CfgAddrW-1:0] {
    CfgPalette     = 3'd0,
    CfgColorCount  = 3'd1,
    CfgOnTicks     = 3'd2,
    CfgOffTicks    = 3'd3,
    CfgBatchSize   = 3'd4,
    CfgRepeatTotal = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic load_slot;
    logic load_base;
    logic mod_step;
    logic emit;
    logic base_wr;
  } pcs_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic base_adv;
    logic restart;
  } pcs_sts_t;

  // colour ROM, RRGGBB
  function automatic logic [3*ChanW-1:0] rgb_lookup(input logic [5:0] idx);
    logic [3*ChanW-1:0] rgb;
    unique case (idx)
      6'd0:  rgb = 24'h000000;
      6'd1:  rgb = 24'hFFFFFF;
      6'd2:  rgb = 24'hFFBFBF;
      6'd3:  rgb = 24'hFFFFBF;
      6'd4:  rgb = 24'hBFFFBF;
      6'd5:  rgb = 24'hBFFFFF;
      6'd6:  rgb = 24'hBFBFFF;
      6'd7:  rgb = 24'hFFBFFF;
      6'd8:  rgb = 24'hFF0000;
      6'd9:  rgb = 24'hFF3F00;
      6'd10: rgb = 24'hFF7F00;
      6'd11: rgb = 24'hFFBF00;
      6'd12: rgb = 24'hFFFF00;
      6'd13: rgb = 24'hBFFF00;
      6'd14: rgb = 24'h7FFF00;
      6'd15: rgb = 24'h3FFF00;
      6'd16: rgb = 24'h00FF00;
      6'd17: rgb = 24'h00FF3F;
      6'd18: rgb = 24'h00FF7F;
      6'd19: rgb = 24'h00FFBF;
      6'd20: rgb = 24'h00FFFF;
      6'd21: rgb = 24'h00BFFF;
      6'd22: rgb = 24'h007FFF;
      6'd23: rgb = 24'h003FFF;
      6'd24: rgb = 24'h0000FF;
      6'd25: rgb = 24'h3F00FF;
      6'd26: rgb = 24'h7F00FF;
      6'd27: rgb = 24'hBF00FF;
      6'd28: rgb = 24'hFF00FF;
      6'd29: rgb = 24'hFF00BF;
      6'd30: rgb = 24'hFF007F;
      6'd31: rgb = 24'hFF003F;
      6'd32: rgb = 24'hFF4040;
      6'd33: rgb = 24'hFF7040;
      6'd34: rgb = 24'hFFA040;
      6'd35: rgb = 24'hFFD040;
      6'd36: rgb = 24'hFFFF40;
      6'd37: rgb = 24'hD0FF40;
      6'd38: rgb = 24'hA0FF40;
      6'd39: rgb = 24'h70FF40;
      6'd40: rgb = 24'h40FF40;
      6'd41: rgb = 24'h40FF70;
      6'd42: rgb = 24'h40FFA0;
      6'd43: rgb = 24'h40FFD0;
      6'd44: rgb = 24'h40FFFF;
      6'd45: rgb = 24'h40D0FF;
      6'd46: rgb = 24'h40A0FF;
      6'd47: rgb = 24'h4070FF;
      6'd48: rgb = 24'h4040FF;
      6'd49: rgb = 24'h7040FF;
      6'd50: rgb = 24'hA040FF;
      6'd51: rgb = 24'hD040FF;
      6'd52: rgb = 24'hFF40FF;
      6'd53: rgb = 24'hFF40D0;
      6'd54: rgb = 24'hFF40A0;
      6'd55: rgb = 24'hFF4070;
      6'd56: rgb = 24'h202020;
      6'd57: rgb = 24'h200000;
      6'd58: rgb = 24'h202000;
      6'd59: rgb = 24'h002000;
      6'd60: rgb = 24'h002020;
      6'd61: rgb = 24'h000020;
      6'd62: rgb = 24'h200020;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

[hw/rtl/pcs_datapath.sv]
`timescale 1ns / 1ps
module pcs_datapath #(
  parameter int unsigned PaletteSlots = pcs_pkg::PaletteSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcs_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pcs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_restart_i,
  input  pcs_pkg::pcs_cmd_t             cmd_i,
  output pcs_pkg::pcs_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcs_pkg::ChanW-1:0]     out_red_o,
  output logic [pcs_pkg::ChanW-1:0]     out_green_o,
  output logic [pcs_pkg::ChanW-1:0]     out_blue_o,
  output logic                          out_lit_o
);
  import pcs_pkg::*;

  localparam logic [CountW-1:0] SlotsMax = CountW'(PaletteSlots);

  logic [CodeW-1:0]    palette_q;
  logic [CountW-1:0]   color_count_q;
  logic [TicksW-1:0]   on_ticks_q;
  logic [TicksW-1:0]   off_ticks_q;
  logic [BatchW-1:0]   batch_size_q;
  logic [RepeatW-1:0]  repeat_total_q;

  logic [TickCntW-1:0] tick_q;
  logic [SlotW-1:0]    base_q;
  logic [BatchW-1:0]   batch_q;
  logic [RepeatW-1:0]  repeat_q;
  logic                restart_q;

  logic [DivW-1:0]     div_q, div_d;
  logic [RemW-1:0]     rem_q, rem_d;

  logic                out_valid_q;
  logic [ChanW-1:0]    red_q, green_q, blue_q;
  logic                lit_q;

  logic [CountW-1:0]   n_eff;
  logic [RemW:0]       part;
  logic [TickCntW-1:0] tick_inc, period;
  logic [BatchW-1:0]   batch_inc;
  logic [RepeatW-1:0]  repeat_inc;
  logic                period_end, batch_wrap, repeat_wrap;
  logic                lit;
  logic [SlotW-1:0]    slot;
  logic [7:0]          code;
  logic [1:0]          shade;
  logic [3*ChanW-1:0]  rgb;

  always_comb begin
    if (color_count_q == '0) begin
      n_eff = CountW'(1);
    end else if (color_count_q > SlotsMax) begin
      n_eff = SlotsMax;
    end else begin
      n_eff = color_count_q;
    end
  end

  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    part  = '0;
    for (int k = 0; k < BitsPerStep; k++) begin
      part = {rem_d, div_d[DivW-1]};
      if (part >= {1'b0, n_eff}) begin
        part = part - {1'b0, n_eff};
      end
      rem_d = part[RemW-1:0];
      div_d = {div_d[DivW-2:0], 1'b0};
    end
  end

  assign tick_inc    = tick_q + TickCntW'(1);
  assign period      = TickCntW'(on_ticks_q) + TickCntW'(off_ticks_q);
  assign period_end  = tick_inc >= period;
  assign batch_inc   = batch_q + BatchW'(1);
  assign batch_wrap  = batch_inc >= batch_size_q;
  assign repeat_inc  = repeat_q + RepeatW'(1);
  assign repeat_wrap = repeat_inc >= repeat_total_q;

  assign lit   = tick_q < TickCntW'(on_ticks_q);
  assign slot  = rem_q[SlotW-1:0];
  assign code  = palette_q[{slot, 3'b000} +: 8];
  assign shade = code[7:6];
  assign rgb   = rgb_lookup(code[5:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q      <= '0;
      color_count_q  <= CountW'(1);
      on_ticks_q     <= '0;
      off_ticks_q    <= '0;
      batch_size_q   <= BatchW'(1);
      repeat_total_q <= RepeatW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgPalette:     palette_q      <= cfg_wdata_i;
        CfgColorCount:  color_count_q  <= cfg_wdata_i[CountW-1:0];
        CfgOnTicks:     on_ticks_q     <= cfg_wdata_i[TicksW-1:0];
        CfgOffTicks:    off_ticks_q    <= cfg_wdata_i[TicksW-1:0];
        CfgBatchSize:   batch_size_q   <= cfg_wdata_i[BatchW-1:0];
        CfgRepeatTotal: repeat_total_q <= cfg_wdata_i[RepeatW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      base_q    <= '0;
      batch_q   <= '0;
      repeat_q  <= '0;
      restart_q <= 1'b0;
    end else begin
      if (cmd_i.load_slot) begin
        restart_q <= in_restart_i;
        if (in_restart_i) begin
          tick_q  <= '0;
          base_q  <= '0;
          batch_q <= '0;
        end
      end
      if (cmd_i.emit && !restart_q) begin
        if (period_end) begin
          tick_q <= '0;
          if (batch_wrap) begin
            batch_q  <= '0;
            repeat_q <= repeat_wrap ? '0 : repeat_inc;
          end else begin
            batch_q <= batch_inc;
          end
        end else begin
          tick_q <= tick_inc;
        end
      end
      if (cmd_i.base_wr) begin
        base_q <= rem_q[SlotW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_slot) begin
      div_q <= in_restart_i ? '0 : DivW'(base_q) + DivW'(batch_q);
      rem_q <= '0;
    end else if (cmd_i.load_base) begin
      div_q <= DivW'(base_q) + DivW'(1);
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      lit_q   <= lit;
      red_q   <= lit ? (rgb[3*ChanW-1:2*ChanW] >> shade) : '0;
      green_q <= lit ? (rgb[2*ChanW-1:ChanW] >> shade) : '0;
      blue_q  <= lit ? (rgb[ChanW-1:0] >> shade) : '0;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign sts_o.base_adv = period_end && batch_wrap && repeat_wrap;
  assign sts_o.restart  = restart_q;

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_lit_o   = lit_q;

endmodule

[hw/rtl/pcs_ctrl.sv]
`timescale 1ns / 1ps
module pcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcs_pkg::pcs_sts_t sts_i,
  output pcs_pkg::pcs_cmd_t cmd_o
);
  import pcs_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SSlot,
    SEmit,
    SBase,
    SBaseWr
  } state_e;

  localparam logic [StepW-1:0] LastStep = StepW'(ModSteps - 1);

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             in_ready_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_slot = (state_q == SIdle) && in_ready_q && in_valid_i;
    unique case (state_q)
      SIdle: ;
      SSlot: cmd_o.mod_step = 1'b1;
      SEmit: begin
        cmd_o.emit      = !sts_i.out_busy;
        cmd_o.load_base = !sts_i.out_busy && !sts_i.restart && sts_i.base_adv;
      end
      SBase:   cmd_o.mod_step = 1'b1;
      SBaseWr: cmd_o.base_wr  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      step_q     <= '0;
      in_ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (in_ready_q && in_valid_i) begin
            state_q    <= SSlot;
            step_q     <= '0;
            in_ready_q <= 1'b0;
          end
        end
        SSlot: begin
          step_q <= step_q + StepW'(1);
          if (step_q == LastStep) begin
            state_q <= SEmit;
          end
        end
        SEmit: begin
          if (!sts_i.out_busy) begin
            if (!sts_i.restart && sts_i.base_adv) begin
              state_q <= SBase;
              step_q  <= '0;
            end else begin
              state_q    <= SIdle;
              in_ready_q <= 1'b1;
            end
          end
        end
        SBase: begin
          step_q <= step_q + StepW'(1);
          if (step_q == LastStep) begin
            state_q <= SBaseWr;
          end
        end
        SBaseWr: begin
          state_q    <= SIdle;
          in_ready_q <= 1'b1;
        end
        default: begin
          state_q    <= SIdle;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

[hw/rtl/palette_candy_strobe_core.sv]
`timescale 1ns / 1ps
// A tick transfer runs 3 remainder steps, then the render step registers the result.
// A tick is taken only after the previous one is finished; when the base colour advances,
// it also makes a second pass through the 3-bits-per-cycle remainder unit and the write-back.
// A stalled output holds the render step; the next tick is taken once rendering and any write-back are done.
// Reset (asynchronous, active low) clears counters and loads register defaults.
module palette_candy_strobe_core #(
  parameter int unsigned PaletteSlots = pcs_pkg::PaletteSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcs_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pcs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pcs_pkg::InDataW-1:0]   s_axis_tdata,  // restart
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pcs_pkg::OutDataW-1:0]  m_axis_tdata   // red, green, blue, lit
);
  import pcs_pkg::*;

  pcs_cmd_t         cmd;
  pcs_sts_t         sts;
  logic [ChanW-1:0] red, green, blue;
  logic             lit;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_datapath #(
    .PaletteSlots (PaletteSlots)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_restart_i (s_axis_tdata[0]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_red_o    (red),
    .out_green_o  (green),
    .out_blue_o   (blue),
    .out_lit_o    (lit)
  );

  assign m_axis_tdata = {(OutDataW - 3 * ChanW - 1)'(0), lit, blue, green, red};

endmodule

[hw/rtl/pcs_checker.sv]
`timescale 1ns / 1ps
`include "palette_candy_strobe_core_macros.svh"
module pcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pcs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import pcs_pkg::*;

  `PCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output dropped while stalled")
  `PCS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output changed while stalled")
  `PCS_ASSERT_NOW(a_blank_black, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[3*ChanW], m_axis_tdata[3*ChanW-1:0] == '0, "blank tick with colour")
  `PCS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "tick taken while busy")

endmodule

bind palette_candy_strobe_core pcs_checker u_pcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
